[sv/ipu_pkg.sv]
`timescale 1ns / 1ps

package ipu_pkg;

   // Palette geometry.
   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_ADDR_W    = $clog2(PALETTE_DEPTH);

   // Command queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Pixel mode register codes.
   localparam logic [1:0] MODE_ONE_BIT   = 2'd0;
   localparam logic [1:0] MODE_FOUR_BIT  = 2'd1;
   localparam logic [1:0] MODE_EIGHT_BIT = 2'd2;
   localparam logic [1:0] MODE_DIRECT    = 2'd3;
   localparam logic [1:0] MODE_RESET     = MODE_EIGHT_BIT;

   // Input opcodes.
   localparam logic OP_PALETTE_WRITE = 1'b0;
   localparam logic OP_IMAGE_DATA    = 1'b1;

   // Work handed from the front end to the back end.
   typedef enum logic [1:0] {
      CMD_PAL_WRITE,
      CMD_LOOKUP,
      CMD_DIRECT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   mode;
      logic [7:0]   data_byte;
      logic [7:0]   index;
      logic [23:0]  bgr;
   } cmd_type;

   // One pixel whose palette read is in flight.
   typedef struct packed {
      logic        last;
      logic        direct;
      logic        black;
      logic [23:0] bgr;
   } flight_type;

   // One finished pixel waiting at the output.
   typedef struct packed {
      logic [23:0] bgr;
      logic        last;
   } pixel_type;

endpackage

[sv/ipu_ram.sv]
`timescale 1ns / 1ps

module ipu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

[sv/ipu_front.sv]
`timescale 1ns / 1ps

module ipu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [7:0]        req_data_byte,
   input  logic [7:0]        req_entry_index,
   input  logic [7:0]        req_entry_blue,
   input  logic [7:0]        req_entry_green,
   input  logic [7:0]        req_entry_red,
   input  logic              queue_full,
   output logic              queue_push,
   output ipu_pkg::cmd_type  queue_cmd
);

   logic [1:0]  mode_ff;
   logic [15:0] gathered_ff;
   logic [15:0] gathered_in;
   logic [1:0]  gcount_ff;
   logic [1:0]  gcount_in;
   logic        accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Classify the accepted transaction and build the back-end command.
   always_comb begin
      gathered_in          = gathered_ff;
      gcount_in            = gcount_ff;
      queue_push           = 1'b0;
      queue_cmd.kind       = ipu_pkg::CMD_LOOKUP;
      queue_cmd.mode       = mode_ff;
      queue_cmd.data_byte  = req_data_byte;
      queue_cmd.index      = req_entry_index;
      queue_cmd.bgr        = {req_entry_red, req_entry_green, req_entry_blue};
      if (accept) begin
         if (req_opcode == ipu_pkg::OP_PALETTE_WRITE) begin
            queue_cmd.kind = ipu_pkg::CMD_PAL_WRITE;
            queue_push     = 1'b1;
         end else if (mode_ff != ipu_pkg::MODE_DIRECT) begin
            queue_push = 1'b1;
         end else begin
            // Direct mode gathers blue, then green, then emits on red.
            unique case (gcount_ff)
               2'd0: begin
                  gathered_in = {gathered_ff[15:8], req_data_byte};
                  gcount_in   = 2'd1;
               end
               2'd1: begin
                  gathered_in = {req_data_byte, gathered_ff[7:0]};
                  gcount_in   = 2'd2;
               end
               default: begin
                  gcount_in      = 2'd0;
                  queue_cmd.kind = ipu_pkg::CMD_DIRECT;
                  queue_cmd.bgr  = {req_data_byte, gathered_ff};
                  queue_push     = 1'b1;
               end
            endcase
         end
      end
   end

   // Mode register and gather state; a mode write drops a partial pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ipu_pkg::MODE_RESET;
         gathered_ff <= 16'h0000;
         gcount_ff   <= 2'd0;
      end else if (csr_write_enable) begin
         mode_ff   <= csr_write_data;
         gcount_ff <= 2'd0;
      end else begin
         gathered_ff <= gathered_in;
         gcount_ff   <= gcount_in;
      end
   end

endmodule

[sv/ipu_queue.sv]
`timescale 1ns / 1ps

module ipu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ipu_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output ipu_pkg::cmd_type  head_cmd
);

   ipu_pkg::cmd_type            entries_ff [ipu_pkg::QUEUE_DEPTH];
   logic [ipu_pkg::QPTR_W-1:0]  wr_ptr_ff;
   logic [ipu_pkg::QPTR_W-1:0]  rd_ptr_ff;
   logic [ipu_pkg::QPTR_W:0]    count_ff;
   logic [ipu_pkg::QPTR_W:0]    count_in;

   localparam logic [ipu_pkg::QPTR_W-1:0] LAST_PTR =
      ipu_pkg::QPTR_W'(ipu_pkg::QUEUE_DEPTH - 1);
   localparam logic [ipu_pkg::QPTR_W:0]   FULL_COUNT =
      (ipu_pkg::QPTR_W + 1)'(ipu_pkg::QUEUE_DEPTH);

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

[sv/ipu_back.sv]
`timescale 1ns / 1ps

module ipu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  ipu_pkg::cmd_type  head_cmd,
   output logic              queue_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic              rsp_last_of_byte
);

   localparam logic [8:0] DEPTH_LIMIT = 9'(ipu_pkg::PALETTE_DEPTH);

   logic [2:0]                     pix_ff;
   logic [2:0]                     pix_in;
   logic [7:0]                     lookup_idx;
   logic                           pix_last;
   logic                           is_write;
   logic                           issue;
   logic                           space_ok;
   logic [1:0]                     occupancy;
   logic                           rsp_pop;
   logic                           pal_write;
   logic [23:0]                    ram_rdata;
   logic                           inflight_ff;
   ipu_pkg::flight_type            flight_ff;
   ipu_pkg::pixel_type             done_pixel;
   ipu_pkg::pixel_type             out_ff [2];
   logic                           out_wr_ptr_ff;
   logic                           out_rd_ptr_ff;
   logic [1:0]                     out_count_ff;
   logic [1:0]                     out_count_in;

   // Select the palette index of the current pixel of the head command.
   always_comb begin
      unique case (head_cmd.mode)
         ipu_pkg::MODE_ONE_BIT: begin
            lookup_idx = {7'b0000000, head_cmd.data_byte[~pix_ff]};
            pix_last   = (pix_ff == 3'd7);
         end
         ipu_pkg::MODE_FOUR_BIT: begin
            lookup_idx = pix_ff[0] ? {4'b0000, head_cmd.data_byte[3:0]}
                                   : {4'b0000, head_cmd.data_byte[7:4]};
            pix_last   = pix_ff[0];
         end
         default: begin
            lookup_idx = head_cmd.data_byte;
            pix_last   = 1'b1;
         end
      endcase
   end

   // Issue a pixel only when the output buffer is sure to have room for it.
   assign rsp_pop   = rsp_valid && !rsp_stall;
   assign occupancy = out_count_ff + {1'b0, inflight_ff};
   assign space_ok  = ((occupancy - {1'b0, rsp_pop}) < 2'd2);
   assign is_write  = (head_cmd.kind == ipu_pkg::CMD_PAL_WRITE);
   assign issue     = head_valid && !is_write && space_ok;
   assign pal_write = head_valid && is_write && ({1'b0, head_cmd.index} < DEPTH_LIMIT);
   assign queue_pop = (head_valid && is_write) || (issue && pix_last);

   always_comb begin
      pix_in = pix_ff;
      if (queue_pop) begin
         pix_in = 3'd0;
      end else if (issue) begin
         pix_in = pix_ff + 3'd1;
      end
   end

   ipu_ram #(
      .WIDTH (24),
      .DEPTH (ipu_pkg::PALETTE_DEPTH)
   ) u_palette (
      .clock        (clock),
      .write_enable (pal_write),
      .write_addr   (head_cmd.index[ipu_pkg::PAL_ADDR_W-1:0]),
      .write_data   (head_cmd.bgr),
      .read_enable  (issue),
      .read_addr    (lookup_idx[ipu_pkg::PAL_ADDR_W-1:0]),
      .read_data    (ram_rdata)
   );

   // Pixel counter and the stage that waits on the palette read.
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff      <= 3'd0;
         inflight_ff <= 1'b0;
      end else begin
         pix_ff      <= pix_in;
         inflight_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         flight_ff.last   <= pix_last;
         flight_ff.direct <= (head_cmd.kind == ipu_pkg::CMD_DIRECT);
         flight_ff.black  <= ({1'b0, lookup_idx} >= DEPTH_LIMIT);
         flight_ff.bgr    <= head_cmd.bgr;
      end
   end

   // Resolve the pixel color once the palette data is back.
   always_comb begin
      done_pixel.last = flight_ff.last;
      if (flight_ff.direct) begin
         done_pixel.bgr = flight_ff.bgr;
      end else if (flight_ff.black) begin
         done_pixel.bgr = 24'h000000;
      end else begin
         done_pixel.bgr = ram_rdata;
      end
   end

   // Two-entry output buffer.
   always_comb begin
      out_count_in = out_count_ff;
      if (inflight_ff && !rsp_pop) begin
         out_count_in = out_count_ff + 2'd1;
      end else if (rsp_pop && !inflight_ff) begin
         out_count_in = out_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (inflight_ff) begin
         out_ff[out_wr_ptr_ff] <= done_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= 1'b0;
         out_rd_ptr_ff <= 1'b0;
         out_count_ff  <= 2'd0;
      end else begin
         if (inflight_ff) begin
            out_wr_ptr_ff <= !out_wr_ptr_ff;
         end
         if (rsp_pop) begin
            out_rd_ptr_ff <= !out_rd_ptr_ff;
         end
         out_count_ff <= out_count_in;
      end
   end

   assign rsp_valid        = (out_count_ff != 2'd0);
   assign rsp_blue         = out_ff[out_rd_ptr_ff].bgr[7:0];
   assign rsp_green        = out_ff[out_rd_ptr_ff].bgr[15:8];
   assign rsp_red          = out_ff[out_rd_ptr_ff].bgr[23:16];
   assign rsp_last_of_byte = out_ff[out_rd_ptr_ff].last;

endmodule

[sv/indexed_pixel_unpacker.sv]
`timescale 1ns / 1ps

// Expands image data bytes into RGB pixels through a 256-entry palette, or
// gathers three bytes into one pixel in direct mode. The back end gives one
// pixel per cycle while its output buffer has room, limited by the single read
// port of the palette RAM: a byte gives eight pixels in one-bit mode, two in
// four-bit mode and one in eight-bit mode; a direct-mode command gives one and
// a palette write none. A byte's first pixel is registered in the four-entry
// command queue, the palette read and the output buffer; the queue lets input
// transactions keep being accepted while earlier pixels are still coming out.
// Palette entries come up undefined after reset and must be written before
// they are used; there is no clearing pass. Write pixel_mode only while idle.
module indexed_pixel_unpacker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_entry_index,
   input  logic [7:0] req_entry_blue,
   input  logic [7:0] req_entry_green,
   input  logic [7:0] req_entry_red,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_last_of_byte
);

   logic             queue_full;
   logic             queue_push;
   ipu_pkg::cmd_type queue_cmd;
   logic             queue_pop;
   logic             head_valid;
   ipu_pkg::cmd_type head_cmd;

   ipu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_entry_index  (req_entry_index),
      .req_entry_blue   (req_entry_blue),
      .req_entry_green  (req_entry_green),
      .req_entry_red    (req_entry_red),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_cmd        (queue_cmd)
   );

   ipu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_cmd   (queue_cmd),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ipu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .queue_pop        (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_last_of_byte (rsp_last_of_byte)
   );

endmodule

[sv/ipu_checker.sv]
`timescale 1ns / 1ps

module ipu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic       rsp_last_of_byte
);

   // A stalled pixel stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("pixel withdrawn while stalled");

   // A stalled pixel keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable({rsp_red, rsp_green, rsp_blue, rsp_last_of_byte}))
      else $error("pixel changed while stalled");

   // Reset empties the output buffer.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("pixel offered right after reset");

   // Reset empties the command queue, so input is taken at once.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind indexed_pixel_unpacker ipu_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_red          (rsp_red),
   .rsp_green        (rsp_green),
   .rsp_blue         (rsp_blue),
   .rsp_last_of_byte (rsp_last_of_byte)
);
